### rtl/core/uirc_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the byte-wide CRC-32 function of the image receive checker.
// No dependencies; every other file refers to this package by scoped names.
package uirc_pkg;

    localparam int LENGTH_BITS_DEFAULT        = 24;
    localparam int PACKET_NUMBER_BITS_DEFAULT = 16;
    localparam int QUEUE_DEPTH_DEFAULT        = 2;

    localparam int CRC_W = 32;
    localparam int BYTE_W = 8;

    localparam logic [CRC_W-1:0] CRC_POLY_REFLECTED = 32'hEDB8_8320;
    localparam logic [CRC_W-1:0] CRC_ALL_ONES       = 32'hFFFF_FFFF;

    typedef enum logic [3:0] {
        ST_ACCEPTED        = 4'd0,
        ST_VERIFIED        = 4'd1,
        ST_DISABLED        = 4'd2,
        ST_BUSY            = 4'd3,
        ST_NOT_STARTED     = 4'd4,
        ST_BAD_PACKET      = 4'd5,
        ST_LENGTH_MISMATCH = 4'd6,
        ST_CRC_MISMATCH    = 4'd7,
        ST_BAD_LENGTH      = 4'd8
    } uirc_status_t;

    // Classification of one item, made by the front end.
    typedef struct packed {
        logic is_data;
        logic first;
        logic last;
        logic len_zero;
    } uirc_cls_t;

    localparam int CLS_W = $bits(uirc_cls_t);

    // Reflected CRC-32 over one byte, LSB first.
    function automatic logic [CRC_W-1:0] crc32_byte(input logic [CRC_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] data);
        logic [CRC_W-1:0] c;
        c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, data};
        for (int k = 0; k < BYTE_W; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY_REFLECTED) : (c >> 1);
        end
        return c;
    endfunction

endpackage

### rtl/core/uirc_front.sv
`timescale 1ns / 1ps
// Front end: accepts input items, classifies them and holds them in one register stage.
// Depends on uirc_pkg.
module uirc_front #(
    parameter int LENGTH_BITS        = uirc_pkg::LENGTH_BITS_DEFAULT,
    parameter int PACKET_NUMBER_BITS = uirc_pkg::PACKET_NUMBER_BITS_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_opcode,
    input  logic [LENGTH_BITS-1:0]        s_image_length,
    input  logic [uirc_pkg::CRC_W-1:0]    s_expected_crc,
    input  logic [PACKET_NUMBER_BITS-1:0] s_packet_number,
    input  logic                          s_first_of_packet,
    input  logic                          s_last_of_packet,
    input  logic [uirc_pkg::BYTE_W-1:0]   s_data_byte,
    output logic                          f_valid,
    input  logic                          f_ready,
    output uirc_pkg::uirc_cls_t           f_cls,
    output logic [LENGTH_BITS-1:0]        f_length,
    output logic [uirc_pkg::CRC_W-1:0]    f_crc,
    output logic [PACKET_NUMBER_BITS-1:0] f_packet,
    output logic [uirc_pkg::BYTE_W-1:0]   f_byte
);

    logic                          valid_reg;
    uirc_pkg::uirc_cls_t           cls_reg;
    uirc_pkg::uirc_cls_t           cls_next;
    logic [LENGTH_BITS-1:0]        length_reg;
    logic [uirc_pkg::CRC_W-1:0]    crc_reg;
    logic [PACKET_NUMBER_BITS-1:0] packet_reg;
    logic [uirc_pkg::BYTE_W-1:0]   byte_reg;
    logic                          take;

    assign s_ready = !valid_reg || f_ready;
    assign take    = s_valid && s_ready;

    always_comb begin
        cls_next.is_data  = s_opcode;
        cls_next.first    = s_first_of_packet;
        cls_next.last     = s_last_of_packet;
        cls_next.len_zero = (s_image_length == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            cls_reg    <= cls_next;
            length_reg <= s_image_length;
            crc_reg    <= s_expected_crc;
            packet_reg <= s_packet_number;
            byte_reg   <= s_data_byte;
        end
    end

    assign f_valid  = valid_reg;
    assign f_cls    = cls_reg;
    assign f_length = length_reg;
    assign f_crc    = crc_reg;
    assign f_packet = packet_reg;
    assign f_byte   = byte_reg;

endmodule

### rtl/core/uirc_queue.sv
`timescale 1ns / 1ps
// Short first-in first-out queue of flip-flops between the front and back ends.
// Depends on uirc_pkg for its default depth.
module uirc_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = uirc_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_data;
        end
    end

    // The fill level never passes the depth.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue fill level beyond depth");

endmodule

### rtl/core/uirc_back.sv
`timescale 1ns / 1ps
// Back end: session state, packet and length checks, CRC update and the result register.
// Depends on uirc_pkg.
module uirc_back #(
    parameter int LENGTH_BITS        = uirc_pkg::LENGTH_BITS_DEFAULT,
    parameter int PACKET_NUMBER_BITS = uirc_pkg::PACKET_NUMBER_BITS_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_wr_data,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  uirc_pkg::uirc_cls_t           cmd_cls,
    input  logic [LENGTH_BITS-1:0]        cmd_length,
    input  logic [uirc_pkg::CRC_W-1:0]    cmd_crc,
    input  logic [PACKET_NUMBER_BITS-1:0] cmd_packet,
    input  logic [uirc_pkg::BYTE_W-1:0]   cmd_byte,
    output logic                          m_valid,
    input  logic                          m_ready,
    output uirc_pkg::uirc_status_t        m_status,
    output logic [LENGTH_BITS-1:0]        m_byte_count
);

    logic                          enabled_reg;
    logic                          active_reg, active_next;
    logic [PACKET_NUMBER_BITS-1:0] next_packet_reg, next_packet_next;
    logic [LENGTH_BITS-1:0]        offset_reg, offset_next;
    logic [uirc_pkg::CRC_W-1:0]    crc_reg, crc_next;
    logic [LENGTH_BITS-1:0]        target_length_reg, target_length_next;
    logic [uirc_pkg::CRC_W-1:0]    target_crc_reg, target_crc_next;
    logic                          m_valid_reg;
    uirc_pkg::uirc_status_t        status_reg, status_next;
    logic [LENGTH_BITS-1:0]        count_reg;
    logic                          pop;
    logic [uirc_pkg::CRC_W-1:0]    crc_upd;
    logic [LENGTH_BITS-1:0]        offset_inc;

    assign cmd_ready = !m_valid_reg || m_ready;
    assign pop       = cmd_valid && cmd_ready;

    assign crc_upd    = uirc_pkg::crc32_byte(crc_reg, cmd_byte);
    assign offset_inc = (offset_reg != '1) ? offset_reg + 1'b1 : offset_reg;

    always_comb begin
        active_next        = active_reg;
        next_packet_next   = next_packet_reg;
        offset_next        = offset_reg;
        crc_next           = crc_reg;
        target_length_next = target_length_reg;
        target_crc_next    = target_crc_reg;
        status_next        = uirc_pkg::ST_ACCEPTED;
        priority if (!enabled_reg) begin
            status_next = uirc_pkg::ST_DISABLED;
        end else if (!cmd_cls.is_data) begin
            priority if (active_reg) begin
                status_next = uirc_pkg::ST_BUSY;
            end else if (cmd_cls.len_zero) begin
                status_next = uirc_pkg::ST_BAD_LENGTH;
            end else begin
                active_next        = 1'b1;
                next_packet_next   = PACKET_NUMBER_BITS'(1);
                offset_next        = '0;
                crc_next           = uirc_pkg::CRC_ALL_ONES;
                target_length_next = cmd_length;
                target_crc_next    = cmd_crc;
            end
        end else if (!active_reg) begin
            status_next = uirc_pkg::ST_NOT_STARTED;
        end else if (cmd_cls.first && (cmd_packet != next_packet_reg)) begin
            active_next = 1'b0;
            status_next = uirc_pkg::ST_BAD_PACKET;
        end else begin
            crc_next    = crc_upd;
            offset_next = offset_inc;
            if (cmd_cls.last) begin
                next_packet_next = next_packet_reg + 1'b1;
                if (offset_inc >= target_length_reg) begin
                    active_next = 1'b0;
                    priority if (offset_inc != target_length_reg) begin
                        status_next = uirc_pkg::ST_LENGTH_MISMATCH;
                    end else if ((crc_upd ^ uirc_pkg::CRC_ALL_ONES) != target_crc_reg) begin
                        status_next = uirc_pkg::ST_CRC_MISMATCH;
                    end else begin
                        status_next = uirc_pkg::ST_VERIFIED;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enabled_reg       <= 1'b1;
            active_reg        <= 1'b0;
            next_packet_reg   <= '0;
            offset_reg        <= '0;
            crc_reg           <= uirc_pkg::CRC_ALL_ONES;
            target_length_reg <= '0;
            target_crc_reg    <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                enabled_reg <= cfg_wr_data;
            end
            if (pop) begin
                active_reg        <= active_next;
                next_packet_reg   <= next_packet_next;
                offset_reg        <= offset_next;
                crc_reg           <= crc_next;
                target_length_reg <= target_length_next;
                target_crc_reg    <= target_crc_next;
            end
            if (cmd_ready) begin
                m_valid_reg <= cmd_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            status_reg <= status_next;
            count_reg  <= offset_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = status_reg;
    assign m_byte_count = count_reg;

    // A session only closes on an item being processed.
    a_close_on_item: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(active_reg) |-> $past(pop))
        else $error("session closed without an item");

    // An item refused because the checker is disabled leaves the count and CRC alone.
    a_disabled_no_change: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && !enabled_reg) |=> ($stable(offset_reg) && $stable(crc_reg)))
        else $error("disabled item changed session state");

    // A verified image always reports exactly the expected length and leaves the session closed.
    a_verified_length: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> (status_reg != uirc_pkg::ST_VERIFIED
                 || (count_reg == target_length_reg && !active_reg)))
        else $error("verified with wrong count or open session");

endmodule

### rtl/core/upgrade_image_receive_checker.sv
`timescale 1ns / 1ps
// Top level of the firmware image receive checker: front end, queue and back end.
// Depends on uirc_pkg, uirc_front, uirc_queue and uirc_back.
//
//  Channel   Direction  Handshake          Carries
//  s_*       in         s_valid/s_ready    start (length, CRC) or one data byte
//  m_*       out        m_valid/m_ready    status and byte count, one per item
//  cfg_*     in         cfg_wr_en          upgrade_enabled register
//
// One item is accepted per cycle in steady state, while m_ready stays high. The front
// register loads at the accepting edge; the item then passes through the queue and
// is presented from the result register. The back end applies the byte-wide CRC-32
// update and the length and packet checks combinationally ahead of that register.
// Reset (aresetn low, synchronous) empties all stages, closes the session and
// sets upgrade_enabled to one. A stall on m_ready fills the result register, then
// the queue, then the front register before s_ready drops.
module upgrade_image_receive_checker #(
    parameter int LENGTH_BITS        = uirc_pkg::LENGTH_BITS_DEFAULT,
    parameter int PACKET_NUMBER_BITS = uirc_pkg::PACKET_NUMBER_BITS_DEFAULT,
    parameter int QUEUE_DEPTH        = uirc_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_opcode,
    input  logic [LENGTH_BITS-1:0]        s_image_length,
    input  logic [31:0]                   s_expected_crc,
    input  logic [PACKET_NUMBER_BITS-1:0] s_packet_number,
    input  logic                          s_first_of_packet,
    input  logic                          s_last_of_packet,
    input  logic [7:0]                    s_data_byte,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [3:0]                    m_status,
    output logic [LENGTH_BITS-1:0]        m_byte_count
);

    // Queue word layout, from the top: classification, length, CRC, packet, byte.
    localparam int BYTE_LSB = 0;
    localparam int PKT_LSB  = BYTE_LSB + uirc_pkg::BYTE_W;
    localparam int CRC_LSB  = PKT_LSB + PACKET_NUMBER_BITS;
    localparam int LEN_LSB  = CRC_LSB + uirc_pkg::CRC_W;
    localparam int CLS_LSB  = LEN_LSB + LENGTH_BITS;
    localparam int Q_W      = CLS_LSB + uirc_pkg::CLS_W;

    // Front end to queue.
    logic                          f_valid;
    logic                          f_ready;
    uirc_pkg::uirc_cls_t           f_cls;
    logic [LENGTH_BITS-1:0]        f_length;
    logic [uirc_pkg::CRC_W-1:0]    f_crc;
    logic [PACKET_NUMBER_BITS-1:0] f_packet;
    logic [uirc_pkg::BYTE_W-1:0]   f_byte;
    logic [Q_W-1:0]                q_in_data;

    // Queue to back end.
    logic                          q_valid;
    logic                          q_ready;
    logic [Q_W-1:0]                q_out_data;
    uirc_pkg::uirc_cls_t           q_cls;
    uirc_pkg::uirc_status_t        status;

    uirc_front #(
        .LENGTH_BITS        (LENGTH_BITS),
        .PACKET_NUMBER_BITS (PACKET_NUMBER_BITS)
    ) u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_opcode          (s_opcode),
        .s_image_length    (s_image_length),
        .s_expected_crc    (s_expected_crc),
        .s_packet_number   (s_packet_number),
        .s_first_of_packet (s_first_of_packet),
        .s_last_of_packet  (s_last_of_packet),
        .s_data_byte       (s_data_byte),
        .f_valid           (f_valid),
        .f_ready           (f_ready),
        .f_cls             (f_cls),
        .f_length          (f_length),
        .f_crc             (f_crc),
        .f_packet          (f_packet),
        .f_byte            (f_byte)
    );

    assign q_in_data = {f_cls, f_length, f_crc, f_packet, f_byte};

    uirc_queue #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (q_in_data),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_out_data)
    );

    assign q_cls = uirc_pkg::uirc_cls_t'(q_out_data[CLS_LSB +: uirc_pkg::CLS_W]);

    uirc_back #(
        .LENGTH_BITS        (LENGTH_BITS),
        .PACKET_NUMBER_BITS (PACKET_NUMBER_BITS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .cmd_valid    (q_valid),
        .cmd_ready    (q_ready),
        .cmd_cls      (q_cls),
        .cmd_length   (q_out_data[LEN_LSB +: LENGTH_BITS]),
        .cmd_crc      (q_out_data[CRC_LSB +: uirc_pkg::CRC_W]),
        .cmd_packet   (q_out_data[PKT_LSB +: PACKET_NUMBER_BITS]),
        .cmd_byte     (q_out_data[BYTE_LSB +: uirc_pkg::BYTE_W]),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (status),
        .m_byte_count (m_byte_count)
    );

    assign m_status = status;

endmodule
